// File: src/csem_pkg.sv
// ----------------------------------------------------------------------------
// csem_pkg: shared types and constants of the counting semaphore table
// Table sizes, derived widths, request/result structs, status and kind codes,
// and the controller/datapath command and status structs.
// ----------------------------------------------------------------------------
`default_nettype none

package csem_pkg;

  localparam int NUM_SEMS    = 8;
  localparam int QUEUE_DEPTH = 8;

  localparam int SLOT_W    = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
  localparam int QPTR_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int MEM_DEPTH = NUM_SEMS * QUEUE_DEPTH;
  localparam int MADDR_W   = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  typedef enum logic [1:0] {
    KIND_INIT  = 2'd0,
    KIND_WAIT  = 2'd1,
    KIND_POST  = 2'd2,
    KIND_CLOSE = 2'd3
  } csem_kind_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_UNKNOWN = 3'd1,
    ST_BLOCKED = 3'd2,
    ST_FULL    = 3'd3,
    ST_QFULL   = 3'd4,
    ST_DUP     = 3'd5
  } csem_status_t;

  typedef struct packed {
    csem_kind_t  kind;
    logic [7:0]  sem_id;
    logic [7:0]  proc_id;
    logic [7:0]  start_count;
  } csem_req_t;

  typedef struct packed {
    csem_status_t status;
    logic         wake_valid;
    logic [7:0]   wake_proc;
    logic [7:0]   count_now;
  } csem_res_t;

  // controller -> datapath
  typedef struct packed {
    logic load;   // capture the request
    logic exec;   // look up the table and apply the update
    logic wake;   // finish a post that released a waiter
  } csem_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic wake_pending;
  } csem_stat_t;

endpackage

`default_nettype wire

// File: src/csem_ctrl.sv
// ----------------------------------------------------------------------------
// csem_ctrl: request sequencer
// Walks each request through capture, table lookup/update and, for a post
// that releases a waiter, an extra wake state for the waiter store read.
// ----------------------------------------------------------------------------
`default_nettype none

module csem_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 start,
  input  csem_pkg::csem_stat_t stat,
  output csem_pkg::csem_cmd_t  cmd,
  output logic                busy
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_LOOK = 3'b010,
    S_WAKE = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (start) state_nxt = S_LOOK;
      S_LOOK: state_nxt = stat.wake_pending ? S_WAKE : S_IDLE;
      S_WAKE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy     = (state_r != S_IDLE);
  assign cmd.load = (state_r == S_IDLE) && start;
  assign cmd.exec = (state_r == S_LOOK);
  assign cmd.wake = (state_r == S_WAKE);

endmodule

`default_nettype wire

// File: src/csem_dp.sv
// ----------------------------------------------------------------------------
// csem_dp: semaphore table datapath
// Holds the entry table, per-entry FIFO pointers and the shared waiter store,
// matches the identifier across all entries and forms the result.
// ----------------------------------------------------------------------------
`default_nettype none

module csem_dp (
  input  wire                  clk,
  input  wire                  rst_n,
  input  csem_pkg::csem_req_t  in_req,
  input  csem_pkg::csem_cmd_t  cmd,
  output csem_pkg::csem_stat_t stat,
  output logic                 out_valid,
  output csem_pkg::csem_res_t  out_res
);

  localparam int NS = csem_pkg::NUM_SEMS;
  localparam int QD = csem_pkg::QUEUE_DEPTH;
  localparam int SW = csem_pkg::SLOT_W;
  localparam int PW = csem_pkg::QPTR_W;
  localparam int FW = csem_pkg::FILL_W;
  localparam int AW = csem_pkg::MADDR_W;

  csem_pkg::csem_req_t req_r;

  logic [NS-1:0] used_r;
  logic [7:0]    ident_r [NS];
  logic [7:0]    count_r [NS];
  logic [PW-1:0] head_r  [NS];
  logic [FW-1:0] fill_r  [NS];

  logic [7:0] wmem [csem_pkg::MEM_DEPTH];
  logic [7:0] wmem_rd_r;

  logic                out_valid_r;
  csem_pkg::csem_res_t out_r;

  logic [NS-1:0] hit_vec;
  logic          hit;
  logic [SW-1:0] hit_slot;
  logic [SW-1:0] free_slot;
  logic          free_any;

  logic [7:0]    cur_cnt;
  logic [PW-1:0] cur_head;
  logic [FW-1:0] cur_fill;
  logic [FW:0]   tail_sum;
  logic [PW-1:0] tail_pos;
  logic [PW-1:0] head_adv;
  logic [AW-1:0] slot_base;

  csem_pkg::csem_res_t res_nxt;
  logic          do_alloc, do_close, cnt_we, do_push, do_pop;
  logic [7:0]    cnt_val;
  logic [AW-1:0] mem_addr;

  always_ff @(posedge clk) begin
    if (cmd.load) req_r <= in_req;
  end

  // parallel identifier match, lowest-index encode of hit and free slot
  always_comb begin
    hit_slot  = '0;
    free_slot = '0;
    for (int i = NS - 1; i >= 0; i--) begin
      hit_vec[i] = used_r[i] && (ident_r[i] == req_r.sem_id);
      if (hit_vec[i]) hit_slot = SW'(i);
      if (!used_r[i]) free_slot = SW'(i);
    end
  end

  assign hit      = |hit_vec;
  assign free_any = ~&used_r;

  assign cur_cnt   = count_r[hit_slot];
  assign cur_head  = head_r[hit_slot];
  assign cur_fill  = fill_r[hit_slot];
  assign tail_sum  = (FW + 1)'(cur_head) + (FW + 1)'(cur_fill);
  assign tail_pos  = (tail_sum >= (FW + 1)'(QD)) ? PW'(tail_sum - (FW + 1)'(QD))
                                                 : PW'(tail_sum);
  assign head_adv  = (cur_head == PW'(QD - 1)) ? '0 : PW'(cur_head + 1'b1);
  assign slot_base = AW'(int'(hit_slot) * QD);

  always_comb begin
    res_nxt    = '0;
    do_alloc   = 1'b0;
    do_close   = 1'b0;
    cnt_we     = 1'b0;
    cnt_val    = cur_cnt;
    do_push    = 1'b0;
    do_pop     = 1'b0;
    mem_addr   = slot_base + AW'(cur_head);
    res_nxt.status = csem_pkg::ST_OK;
    if (req_r.kind == csem_pkg::KIND_INIT) begin
      if (hit) begin
        res_nxt.status    = csem_pkg::ST_DUP;
        res_nxt.count_now = cur_cnt;
      end else if (!free_any) begin
        res_nxt.status = csem_pkg::ST_FULL;
      end else begin
        do_alloc          = 1'b1;
        res_nxt.count_now = req_r.start_count;
      end
    end else if (!hit) begin
      res_nxt.status = csem_pkg::ST_UNKNOWN;
    end else begin
      unique case (req_r.kind)
        csem_pkg::KIND_WAIT: begin
          if (cur_cnt != 8'd0) begin
            cnt_we  = 1'b1;
            cnt_val = cur_cnt - 8'd1;
          end else if (cur_fill == FW'(QD)) begin
            res_nxt.status = csem_pkg::ST_QFULL;
          end else begin
            do_push        = 1'b1;
            mem_addr       = slot_base + AW'(tail_pos);
            res_nxt.status = csem_pkg::ST_BLOCKED;
          end
          res_nxt.count_now = cnt_val;
        end
        csem_pkg::KIND_POST: begin
          if (cur_fill != '0) begin
            do_pop             = 1'b1;
            res_nxt.wake_valid = 1'b1;
          end else if (cur_cnt != 8'hFF) begin
            cnt_we  = 1'b1;
            cnt_val = cur_cnt + 8'd1;
          end
          res_nxt.count_now = cnt_val;
        end
        csem_pkg::KIND_CLOSE: do_close = 1'b1;
        default: ;
      endcase
    end
  end

  // entry table control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      for (int i = 0; i < NS; i++) begin
        head_r[i] <= '0;
        fill_r[i] <= '0;
      end
    end else if (cmd.exec) begin
      if (do_alloc) begin
        used_r[free_slot] <= 1'b1;
        head_r[free_slot] <= '0;
        fill_r[free_slot] <= '0;
      end
      if (do_close) begin
        used_r[hit_slot] <= 1'b0;
        head_r[hit_slot] <= '0;
        fill_r[hit_slot] <= '0;
      end
      if (do_push) fill_r[hit_slot] <= cur_fill + 1'b1;
      if (do_pop) begin
        head_r[hit_slot] <= head_adv;
        fill_r[hit_slot] <= cur_fill - 1'b1;
      end
    end
  end

  // entry payload
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (do_alloc) begin
        ident_r[free_slot] <= req_r.sem_id;
        count_r[free_slot] <= req_r.start_count;
      end
      if (cnt_we) count_r[hit_slot] <= cnt_val;
    end
  end

  // waiter store: one write or one registered read per request
  always_ff @(posedge clk) begin
    if (cmd.exec && do_push) wmem[mem_addr] <= req_r.proc_id;
    if (cmd.exec && do_pop)  wmem_rd_r <= wmem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (cmd.exec && !do_pop) || cmd.wake;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_r <= res_nxt;
    end else if (cmd.wake) begin
      out_r.wake_proc <= wmem_rd_r;
    end
  end

  assign stat.wake_pending = do_pop;
  assign out_valid         = out_valid_r;
  assign out_res           = out_r;

endmodule

`default_nettype wire

// File: src/counting_semaphore_table.sv
// ----------------------------------------------------------------------------
// counting_semaphore_table: table of counting semaphores with FIFO wait queues
// The result strobe is registered after the table lookup; a post that releases
//   a waiter also passes a registered read of the waiter store and a wake step.
// A request is taken only while busy is low; busy stays high until it is done.
// The receiver cannot stall; each result is shown for one cycle only.
// Reset (synchronous, rst_n low) empties the table and all wait queues.
// ----------------------------------------------------------------------------
`default_nettype none

module counting_semaphore_table (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 start,
  output logic                busy,
  input  csem_pkg::csem_req_t in_req,
  output logic                out_valid,
  output csem_pkg::csem_res_t out_res
);

  csem_pkg::csem_cmd_t  cmd;
  csem_pkg::csem_stat_t stat;

  csem_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  csem_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted request did not raise busy");

  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("results on back-to-back cycles");

  a_wake_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.wake_valid |->
      out_res.status == csem_pkg::ST_OK && out_res.count_now == 8'd0)
    else $error("wake with nonzero count or bad status");

  a_no_wake_proc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_res.wake_valid |-> out_res.wake_proc == 8'd0)
    else $error("wake_proc set without a wake");

endmodule

`default_nettype wire
